// ===== rtl/tba_pkg.sv =====
package tba_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_X = 3'd0,
    CFG_MIN_Y = 3'd1,
    CFG_MIN_Z = 3'd2,
    CFG_MAX_X = 3'd3,
    CFG_MAX_Y = 3'd4,
    CFG_MAX_Z = 3'd5
  } cfg_idx_e;

  // Box reset: lower corner 0.0, upper corner 1.0 in 8 fraction bits
  localparam int BOX_MIN_RST = 0;
  localparam int BOX_MAX_RST = 256;

  // Register stages from input word to output word
  localparam int NUM_STAGES = 6;

endpackage

// ===== rtl/triangle_box_overlap.sv =====
// Triangle versus axis-aligned box overlap test (separating axis).
// Config: cfg_we_i writes cfg_data_i into the box corner register selected by
// cfg_idx_i (min x, y, z, then max x, y, z); indexes above five are dropped.
// Write the box only while no word is in flight.
// Slave side: one triangle word per handshake, tdata holds the nine vertex
// coordinates (a.x .. c.z) then the tag. Master side: one result word per
// triangle, tdata holds the overlap flag in bit 0 and the tag above it.
// Touching counts as overlap.
// Throughput: one triangle per cycle unless the master side stalls. Six
// register stages: box extents and edges, edge-axis products, sums and
// normal, edge-axis compare and split normal products, normal projections,
// output register.
// Reset clears all stage valid bits and loads the unit box [0, 1].
// When the master side stalls, the stages close up behind the output word and
// empty slots still fill; tready drops only once every stage holds a word.
module triangle_box_overlap import tba_pkg::*; #(
  parameter int COORD_BITS = 24,
  parameter int TAG_BITS   = 24,
  localparam int IN_DATA_W  = ((9*COORD_BITS + TAG_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((1 + TAG_BITS + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]   cfg_data_i,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // vert_a_x, vert_a_y, vert_a_z, vert_b_x .. vert_c_z, tri_tag, zero fill
  input  logic [IN_DATA_W-1:0]    s_axis_tdata_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // overlaps, tag_out, zero fill
  output logic [OUT_DATA_W-1:0]   m_axis_tdata_o
);

  localparam int W   = COORD_BITS;
  localparam int DW  = W + 2;        // doubled vertex minus doubled centre
  localparam int EW  = W + 1;        // edge, edge magnitude, half size
  localparam int PEW = 2 * W + 4;    // edge-axis products and sums
  localparam int NPW = 2 * W + 2;    // normal cross products
  localparam int NW  = 2 * W + 3;    // normal components
  localparam int LB  = W + 1;        // low split of a normal component
  localparam int QW  = 2 * W + 4;    // split products
  localparam int PW  = 3 * W + 7;    // normal-axis projections
  localparam int NS  = NUM_STAGES;

  // ---------------------------------------------------------------- control
  logic [NS-1:0] v_q, v_d, en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || m_axis_tready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        v_d[k] = (k == 0) ? s_axis_tvalid_i : v_q[(k == 0) ? 0 : k - 1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready_o = en[0];

  // ---------------------------------------------------------------- box regs
  logic signed [W-1:0] box_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q[CFG_MIN_X] <= W'(BOX_MIN_RST);
      box_q[CFG_MIN_Y] <= W'(BOX_MIN_RST);
      box_q[CFG_MIN_Z] <= W'(BOX_MIN_RST);
      box_q[CFG_MAX_X] <= W'(BOX_MAX_RST);
      box_q[CFG_MAX_Y] <= W'(BOX_MAX_RST);
      box_q[CFG_MAX_Z] <= W'(BOX_MAX_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_X: box_q[CFG_MIN_X] <= cfg_data_i;
        CFG_MIN_Y: box_q[CFG_MIN_Y] <= cfg_data_i;
        CFG_MIN_Z: box_q[CFG_MIN_Z] <= cfg_data_i;
        CFG_MAX_X: box_q[CFG_MAX_X] <= cfg_data_i;
        CFG_MAX_Y: box_q[CFG_MAX_Y] <= cfg_data_i;
        CFG_MAX_Z: box_q[CFG_MAX_Z] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [W-1:0]  vin   [3][3];
  logic [TAG_BITS-1:0]  tag_in;
  logic signed [DW-1:0] d1_d  [3][3];
  logic signed [EW-1:0] e1_d  [3][3];
  logic signed [EW-1:0] ea1_d [3][3];
  logic signed [EW-1:0] h1_d  [3];
  logic                 box_ok1_d;

  logic signed [DW-1:0] d1_q  [3][3];
  logic signed [EW-1:0] e1_q  [3][3];
  logic signed [EW-1:0] ea1_q [3][3];
  logic signed [EW-1:0] h1_q  [3];
  logic                 box_ok1_q;
  logic [TAG_BITS-1:0]  tag1_q;

  always_comb begin
    logic signed [W:0] c2;
    logic [2:0]        lt_min, gt_max;
    logic              sep;
    sep = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        vin[i][k] = s_axis_tdata_i[(i*3+k)*W +: W];
      end
    end
    tag_in = s_axis_tdata_i[9*W +: TAG_BITS];
    for (int k = 0; k < 3; k++) begin
      c2       = (W+1)'(box_q[k]) + (W+1)'(box_q[3+k]);
      h1_d[k]  = EW'(box_q[3+k]) - EW'(box_q[k]);
      for (int i = 0; i < 3; i++) begin
        d1_d[i][k] = (DW'(vin[i][k]) <<< 1) - DW'(c2);
        lt_min[i]  = vin[i][k] < box_q[k];
        gt_max[i]  = vin[i][k] > box_q[3+k];
      end
      sep = sep || (&lt_min) || (&gt_max);
    end
    box_ok1_d = !sep;
    // edge i runs from vertex i to the next vertex
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        e1_d[i][k] = EW'(vin[(i+1)%3][k]) - EW'(vin[i][k]);
        if (vin[(i+1)%3][k] < vin[i][k]) begin
          ea1_d[i][k] = EW'(vin[i][k]) - EW'(vin[(i+1)%3][k]);
        end else begin
          ea1_d[i][k] = EW'(vin[(i+1)%3][k]) - EW'(vin[i][k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d1_q      <= d1_d;
      e1_q      <= e1_d;
      ea1_q     <= ea1_d;
      h1_q      <= h1_d;
      box_ok1_q <= box_ok1_d;
      tag1_q    <= tag_in;
    end
  end

  // edge-axis products and normal cross products
  // Edge axes: category a crosses box axis a with edge i; nonzero components
  // u = a+1 and w = a+2 (mod 3), axis[u] = -e[w], axis[w] = e[u].
  logic signed [PEW-1:0] pu2_d [3][3][3];
  logic signed [PEW-1:0] pw2_d [3][3][3];
  logic signed [PEW-1:0] ru2_d [3][3];
  logic signed [PEW-1:0] rw2_d [3][3];
  logic signed [NPW-1:0] np2_d [3][2];

  logic signed [PEW-1:0] pu2_q [3][3][3];
  logic signed [PEW-1:0] pw2_q [3][3][3];
  logic signed [PEW-1:0] ru2_q [3][3];
  logic signed [PEW-1:0] rw2_q [3][3];
  logic signed [NPW-1:0] np2_q [3][2];
  logic signed [DW-1:0]  d2_q  [3][3];
  logic signed [EW-1:0]  h2_q  [3];
  logic                  box_ok2_q;
  logic [TAG_BITS-1:0]   tag2_q;

  always_comb begin
    int u, w;
    for (int a = 0; a < 3; a++) begin
      u = (a + 1) % 3;
      w = (a + 2) % 3;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pu2_d[a][i][k] = PEW'(d1_q[k][u]) * PEW'(e1_q[i][w]);
          pw2_d[a][i][k] = PEW'(d1_q[k][w]) * PEW'(e1_q[i][u]);
        end
        ru2_d[a][i] = PEW'(h1_q[u]) * PEW'(ea1_q[i][w]);
        rw2_d[a][i] = PEW'(h1_q[w]) * PEW'(ea1_q[i][u]);
      end
    end
    // normal = e0 x e1
    for (int c = 0; c < 3; c++) begin
      np2_d[c][0] = NPW'(e1_q[0][(c+1)%3]) * NPW'(e1_q[1][(c+2)%3]);
      np2_d[c][1] = NPW'(e1_q[0][(c+2)%3]) * NPW'(e1_q[1][(c+1)%3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pu2_q     <= pu2_d;
      pw2_q     <= pw2_d;
      ru2_q     <= ru2_d;
      rw2_q     <= rw2_d;
      np2_q     <= np2_d;
      d2_q      <= d1_q;
      h2_q      <= h1_q;
      box_ok2_q <= box_ok1_q;
      tag2_q    <= tag1_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [PEW-1:0] pe3_d [3][3][3];
  logic signed [PEW-1:0] re3_d [3][3];
  logic signed [NW-1:0]  n3_d  [3];
  logic signed [NW-1:0]  na3_d [3];

  logic signed [PEW-1:0] pe3_q [3][3][3];
  logic signed [PEW-1:0] re3_q [3][3];
  logic signed [NW-1:0]  n3_q  [3];
  logic signed [NW-1:0]  na3_q [3];
  logic signed [DW-1:0]  d3_q  [3][3];
  logic signed [EW-1:0]  h3_q  [3];
  logic                  box_ok3_q;
  logic [TAG_BITS-1:0]   tag3_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pe3_d[a][i][k] = pw2_q[a][i][k] - pu2_q[a][i][k];
        end
        re3_d[a][i] = ru2_q[a][i] + rw2_q[a][i];
      end
    end
    for (int c = 0; c < 3; c++) begin
      n3_d[c] = NW'(np2_q[c][0]) - NW'(np2_q[c][1]);
      if (np2_q[c][0] < np2_q[c][1]) begin
        na3_d[c] = NW'(np2_q[c][1]) - NW'(np2_q[c][0]);
      end else begin
        na3_d[c] = NW'(np2_q[c][0]) - NW'(np2_q[c][1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pe3_q     <= pe3_d;
      re3_q     <= re3_d;
      n3_q      <= n3_d;
      na3_q     <= na3_d;
      d3_q      <= d2_q;
      h3_q      <= h2_q;
      box_ok3_q <= box_ok2_q;
      tag3_q    <= tag2_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic [8:0]           eok_ax;
  logic signed [QW-1:0] dlo4_d [3][3];
  logic signed [QW-1:0] dhi4_d [3][3];
  logic signed [QW-1:0] hlo4_d [3];
  logic signed [QW-1:0] hhi4_d [3];

  logic signed [QW-1:0] dlo4_q [3][3];
  logic signed [QW-1:0] dhi4_q [3][3];
  logic signed [QW-1:0] hlo4_q [3];
  logic signed [QW-1:0] hhi4_q [3];
  logic                 eok4_q;
  logic                 box_ok4_q;
  logic [TAG_BITS-1:0]  tag4_q;

  for (genvar a = 0; a < 3; a++) begin : g_cat
    for (genvar i = 0; i < 3; i++) begin : g_edge
      tba_axis_test #(
        .WIDTH (PEW)
      ) u_edge_axis (
        .p_i  (pe3_q[a][i]),
        .r_i  (re3_q[a][i]),
        .ok_o (eok_ax[a*3+i])
      );
    end
  end

  // split each normal component into a signed high part and an unsigned low part
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        dlo4_d[k][c] = QW'(d3_q[k][c]) * QW'($signed({1'b0, n3_q[c][LB-1:0]}));
        dhi4_d[k][c] = QW'(d3_q[k][c]) * QW'($signed(n3_q[c][NW-1:LB]));
      end
      hlo4_d[c] = QW'(h3_q[c]) * QW'($signed({1'b0, na3_q[c][LB-1:0]}));
      hhi4_d[c] = QW'(h3_q[c]) * QW'($signed(na3_q[c][NW-1:LB]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      dlo4_q    <= dlo4_d;
      dhi4_q    <= dhi4_d;
      hlo4_q    <= hlo4_d;
      hhi4_q    <= hhi4_d;
      eok4_q    <= &eok_ax;
      box_ok4_q <= box_ok3_q;
      tag4_q    <= tag3_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic signed [PW-1:0] pn5_d [3];
  logic signed [PW-1:0] rn5_d;
  logic signed [PW-1:0] pn5_q [3];
  logic signed [PW-1:0] rn5_q;
  logic                 eok5_q;
  logic                 box_ok5_q;
  logic [TAG_BITS-1:0]  tag5_q;

  always_comb begin
    rn5_d = '0;
    for (int k = 0; k < 3; k++) begin
      pn5_d[k] = '0;
      for (int c = 0; c < 3; c++) begin
        pn5_d[k] = pn5_d[k] + (PW'(dhi4_q[k][c]) <<< LB) + PW'(dlo4_q[k][c]);
      end
    end
    for (int c = 0; c < 3; c++) begin
      rn5_d = rn5_d + (PW'(hhi4_q[c]) <<< LB) + PW'(hlo4_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      pn5_q     <= pn5_d;
      rn5_q     <= rn5_d;
      eok5_q    <= eok4_q;
      box_ok5_q <= box_ok4_q;
      tag5_q    <= tag4_q;
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic                nok;
  logic                ovl_q;
  logic [TAG_BITS-1:0] tag6_q;

  tba_axis_test #(
    .WIDTH (PW)
  ) u_normal_axis (
    .p_i  (pn5_q),
    .r_i  (rn5_q),
    .ok_o (nok)
  );

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      ovl_q  <= box_ok5_q && eok5_q && nok;
      tag6_q <= tag5_q;
    end
  end

  assign m_axis_tvalid_o = v_q[NS-1];
  assign m_axis_tdata_o  = OUT_DATA_W'({tag6_q, ovl_q});

  // ---------------------------------------------------------------- checks
  a_empty_out_accepts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked while output stage is empty");

  a_stall_from_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (v_q[NS-1] && !m_axis_tready_i))
    else $error("input blocked without output backpressure");

  a_full_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&v_q) && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted into a full stalled pipeline");

endmodule

// ===== rtl/tba_axis_test.sv =====
module tba_axis_test #(
  parameter int WIDTH = 52
) (
  input  logic signed [WIDTH-1:0] p_i [3],
  input  logic signed [WIDTH-1:0] r_i,
  output logic                    ok_o
);

  logic signed [WIDTH:0] r_pos;
  logic signed [WIDTH:0] r_neg;
  logic [2:0]            below;
  logic [2:0]            above;

  // Separated only when all three projections lie strictly below -r or all strictly above r
  always_comb begin
    r_pos = (WIDTH+1)'(r_i);
    r_neg = -r_pos;
    for (int k = 0; k < 3; k++) begin
      below[k] = (WIDTH+1)'(p_i[k]) < r_neg;
      above[k] = (WIDTH+1)'(p_i[k]) > r_pos;
    end
    ok_o = !((&below) || (&above));
  end

endmodule

// ===== bench/tb_triangle_box_overlap.sv =====
module tb_triangle_box_overlap;
  import tba_pkg::*;

  localparam int CB         = 24;
  localparam int TB         = 24;
  localparam int IN_W       = ((9*CB + TB + 7) / 8) * 8;
  localparam int OUT_W      = ((1 + TB + 7) / 8) * 8;
  localparam int CYCLE_CAP  = 400000;
  localparam int LONG_HOLD  = 400;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_NONE = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_TOP  = 3'd7;
  localparam logic signed [CB-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [CB-1:0] C_MIN = 24'sh800000;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    coord_t         crd[9];
    logic [TB-1:0]  tag;
    bit             typed;
    bit             hit;
  } tri_row_t;

  typedef struct {
    bit             hit;
    logic [TB-1:0]  tag;
  } hit_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [CB-1:0]           cfg_data_i = '0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [IN_W-1:0]         s_axis_tdata_i = '0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]        m_axis_tdata_o;

  coord_t    box_lo[3];
  coord_t    box_hi[3];
  hit_word_t pending_hits[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        burst_left = 0;
  int        hold_token = 0;

  triangle_box_overlap #(.COORD_BITS(CB), .TAG_BITS(TB)) u_top (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic wide_t mag(wide_t a);
    return (a < 0) ? -a : a;
  endfunction

  // true when this axis leaves triangle and box touching or overlapping
  function automatic bit axis_open(wide_t ax[3], wide_t d[3][3], wide_t h[3]);
    wide_t p[3];
    wide_t r, lo, hi;
    for (int i = 0; i < 3; i++) p[i] = d[i][0]*ax[0] + d[i][1]*ax[1] + d[i][2]*ax[2];
    r  = h[0]*mag(ax[0]) + h[1]*mag(ax[1]) + h[2]*mag(ax[2]);
    lo = p[0];
    hi = p[0];
    for (int i = 1; i < 3; i++) begin
      if (p[i] < lo) lo = p[i];
      if (p[i] > hi) hi = p[i];
    end
    return !(hi < -r || r < lo);
  endfunction

  function automatic bit tri_hits_box(coord_t crd[9]);
    wide_t v[3][3], d[3][3], e[3][3], h[3], ax[3];
    wide_t tmin, tmax, lo, hi;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) v[i][k] = crd[i*3+k];
    for (int k = 0; k < 3; k++) begin
      lo = box_lo[k];
      hi = box_hi[k];
      tmin = v[0][k];
      tmax = v[0][k];
      for (int i = 1; i < 3; i++) begin
        if (v[i][k] < tmin) tmin = v[i][k];
        if (v[i][k] > tmax) tmax = v[i][k];
      end
      if (tmax < lo || hi < tmin) return 1'b0;
      h[k] = hi - lo;
      for (int i = 0; i < 3; i++) d[i][k] = 2*v[i][k] - (lo + hi);
      e[0][k] = v[1][k] - v[0][k];
      e[1][k] = v[2][k] - v[1][k];
      e[2][k] = v[0][k] - v[2][k];
    end
    for (int i = 0; i < 3; i++) begin
      ax[0] = 0;          ax[1] = -e[i][2]; ax[2] = e[i][1];
      if (!axis_open(ax, d, h)) return 1'b0;
      ax[0] = e[i][2];    ax[1] = 0;        ax[2] = -e[i][0];
      if (!axis_open(ax, d, h)) return 1'b0;
      ax[0] = -e[i][1];   ax[1] = e[i][0];  ax[2] = 0;
      if (!axis_open(ax, d, h)) return 1'b0;
    end
    ax[0] = e[0][1]*e[1][2] - e[0][2]*e[1][1];
    ax[1] = e[0][2]*e[1][0] - e[0][0]*e[1][2];
    ax[2] = e[0][0]*e[1][1] - e[0][1]*e[1][0];
    return axis_open(ax, d, h);
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, coord_t val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx < 3) box_lo[idx] = val;
    else if (idx < 6) box_hi[idx-3] = val;
  endtask

  task automatic set_box(coord_t lx, coord_t ly, coord_t lz, coord_t hx, coord_t hy,
                         coord_t hz);
    write_reg(CFG_MIN_X, lx);
    write_reg(CFG_MIN_Y, ly);
    write_reg(CFG_MIN_Z, lz);
    write_reg(CFG_MAX_X, hx);
    write_reg(CFG_MAX_Y, hy);
    write_reg(CFG_MAX_Z, hz);
    // out-of-range indexes must leave the box alone
    write_reg(CFG_IDX_NONE, coord_t'($urandom));
    write_reg(CFG_IDX_TOP, coord_t'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_tri(tri_row_t t);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {t.tag, t.crd[8], t.crd[7], t.crd[6], t.crd[5], t.crd[4],
                        t.crd[3], t.crd[2], t.crd[1], t.crd[0]};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_hits.insert(pending_hits.size(),
                        hit_word_t'{t.typed ? t.hit : tri_hits_box(t.crd), t.tag});
    burst_left--;
  endtask

  // stop offering, then wait out every result and the pipeline depth
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (NUM_STAGES + 4) @(posedge clk_i);
  endtask

  function automatic coord_t near_coord(int k);
    longint lo, span, val;
    lo   = box_lo[k];
    span = longint'(box_hi[k]) - lo;
    if (span < 0) begin
      lo   = box_hi[k];
      span = -span;
    end
    if (span < 16) span = 16;
    val = lo - span/2 + $urandom_range(0, 1000) * (2*span) / 1000;
    if (val > 8388607) val = 8388607;
    if (val < -8388608) val = -8388608;
    return coord_t'(val);
  endfunction

  function automatic tri_row_t rand_tri();
    tri_row_t t;
    int mode;
    mode = $urandom_range(0, 9);
    for (int j = 0; j < 9; j++) begin
      if (mode < 7) t.crd[j] = near_coord(j % 3);
      else t.crd[j] = coord_t'($urandom);
    end
    // collapse onto another vertex now and then
    if ($urandom_range(0, 15) == 0)
      for (int k = 0; k < 3; k++) t.crd[3+k] = t.crd[k];
    t.tag   = TB'($urandom);
    t.typed = 1'b0;
    t.hit   = 1'b0;
    return t;
  endfunction

  always @(posedge clk_i) begin
    hit_word_t exp_w;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata_o);
      end else begin
        exp_w = pending_hits.pop_front();
        if (m_axis_tdata_o[0] !== exp_w.hit || m_axis_tdata_o[TB:1] !== exp_w.tag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit %0d tag %h, got hit %0d tag %h", exp_w.hit,
                     exp_w.tag, m_axis_tdata_o[0], m_axis_tdata_o[TB:1]);
        end
      end
    end
  end

  // receiver: stall pattern switches among four modes; long hold on request
  always @(posedge clk_i) begin
    static int mode = 0;
    static int seen = 0;
    static int hold_left = 0;
    if (cycles % 100 == 0) mode = $urandom_range(0, 3);
    if (hold_token != seen) begin
      seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= $urandom_range(0, 1);
        2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    tri_row_t rows[$];
    tri_row_t t;
    coord_t lx, ly, lz;
    box_lo = '{0, 0, 0};
    box_hi = '{BOX_MAX_RST, BOX_MAX_RST, BOX_MAX_RST};

    // reset box is the unit cube
    rows.insert(rows.size(),
                '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 24'h000000, 1, 1});
    rows.insert(rows.size(),
                '{'{256, 256, 256, 512, 512, 512, 300, 700, 256}, 24'hFFFFFF, 1, 1});
    rows.insert(rows.size(),
                '{'{257, 0, 0, 600, 100, 0, 900, 0, 200}, 24'h000001, 1, 0});
    rows.insert(rows.size(),
                '{'{-1, -1, -1, -50, -9, -3, -7, -70, -2}, 24'h800000, 1, 0});
    rows.insert(rows.size(),
                '{'{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX},
                  24'h555555, 1, 0});
    rows.insert(rows.size(),
                '{'{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN},
                  24'hAAAAAA, 1, 0});
    rows.insert(rows.size(),
                '{'{128, 128, 128, 128, 128, 128, 128, 128, 128}, 24'h123456, 1, 1});
    // huge triangle cutting the cube, normal axis decides
    rows.insert(rows.size(),
                '{'{C_MIN, C_MIN, 128, C_MAX, C_MIN, 128, 0, C_MAX, 128}, 24'h0F0F0F,
                  0, 0});
    rows.insert(rows.size(),
                '{'{C_MIN, 0, C_MIN, C_MAX, 300, C_MAX, C_MAX, 300, C_MIN}, 24'hF0F0F0,
                  0, 0});
    // corner-grazing slab: edge axes separate
    rows.insert(rows.size(),
                '{'{-100, 200, 128, 200, -100, 128, 500, 500, 900}, 24'h00FF00, 0, 0});
    rows.insert(rows.size(),
                '{'{-300, 300, 0, 300, -300, 0, 300, -300, 256}, 24'h0000FF, 0, 0});
    // collinear vertices with zero normal, then a triangle in the plane y = 300
    rows.insert(rows.size(),
                '{'{-10, -10, -10, 100, 100, 100, 300, 300, 300}, 24'hFF0000, 0, 0});
    rows.insert(rows.size(),
                '{'{-10, 300, 0, 100, 300, 100, 300, 300, 300}, 24'h00AA00, 0, 0});
    rows.insert(rows.size(),
                '{'{C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 0, 0, 0}, 24'h7FFFFF,
                  0, 0});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_tri(rows[i]);
    drain();

    set_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    foreach (rows[i]) begin
      t = rows[i];
      t.typed = 1'b0;
      send_tri(t);
    end
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_box(-1000, -500, 0, 1000, 500, 2000);
        1: set_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        2: set_box(500, 500, 500, -500, -500, -500);   // inverted box
        3: set_box(77, 77, 77, 77, 77, 77);           // single point
        default: begin
          lx = coord_t'($urandom);
          ly = coord_t'($urandom_range(0, 4000)) - 2000;
          lz = coord_t'($urandom);
          set_box(lx, ly, lz, lx + coord_t'($urandom_range(0, 60000)),
                  ly + coord_t'($urandom_range(0, 3000)),
                  lz + coord_t'($urandom_range(0, 1 << 20)));
        end
      endcase
      if (ph == 4) hold_token++;
      repeat (265) send_tri(rand_tri());
      if (ph == 5) begin
        drain();
        repeat (10) send_tri(rand_tri());
      end
      drain();
    end

    if (mismatches == 0 && pending_hits.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
